>>> design/arp_cache_table_core_assert.svh
// assertion macros for the address cache rtl
// used by design/arp_cache_table_core.sv; no other dependencies
`ifndef ARP_CACHE_TABLE_CORE_ASSERT_SVH
`define ARP_CACHE_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ARPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("arp cache assertion failed");
// expression must never be true outside reset
`define ARPC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("arp cache forbidden condition seen");
`else
`define ARPC_ASSERT(lbl, clk, rstn, prop)
`define ARPC_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> design/arpc_pkg.sv
// shared types and constants for the address cache
// no dependencies; imported by arpc_slot_ram.sv and arp_cache_table_core.sv
`default_nettype none

package arpc_pkg;

  localparam int unsigned IpW      = 32;
  localparam int unsigned MacW     = 48;
  localparam int unsigned CountW   = 5;
  // address width that covers the largest supported table (256 slots)
  localparam int unsigned SlotIdxW = 8;

  localparam logic [CountW-1:0] CountMax     = '1;
  localparam logic [MacW-1:0]   BroadcastMac = {6{8'hFF}};

  // command codes on the request channel
  typedef enum logic [1:0] {
    CMD_LOOKUP       = 2'd0,
    CMD_MARK_PENDING = 2'd1,
    CMD_INSERT       = 2'd2,
    CMD_FLUSH        = 2'd3
  } cmd_e;

  // slot states as stored in the memory
  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_PENDING  = 2'd1,
    SLOT_RESOLVED = 2'd2
  } slot_state_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } fsm_state_e;

  // one memory word
  typedef struct packed {
    slot_state_e          state;
    logic [IpW-1:0]       ip;
    logic [MacW-1:0]      mac;
  } slot_word_t;

  // request from the controller to the slot memory
  typedef struct packed {
    logic                 rd_en;
    logic [SlotIdxW-1:0]  rd_addr;
    logic                 wr_en;
    logic [SlotIdxW-1:0]  wr_addr;
    slot_word_t           wr_data;
    logic                 clear;
  } ram_req_t;

endpackage

`default_nettype wire

>>> design/arpc_ifs.sv
// valid/ready channel interfaces for the address cache
// request channel and response channel; no dependencies
`default_nettype none

interface arpc_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] ip;
  logic [47:0] mac;

  modport source (output valid, output cmd, output ip, output mac, input ready);
  modport sink   (input valid, input cmd, input ip, input mac, output ready);
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] mac_out;
  logic [4:0]  entry_count;

  modport source (output valid, output hit, output mac_out, output entry_count,
                  input ready);
  modport sink   (input valid, input hit, input mac_out, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> design/arpc_slot_ram.sv
// slot memory: ip, mac and state words with a registered read
// per-slot written flags make unwritten slots read as empty; uses arpc_pkg
`default_nettype none

module arpc_slot_ram
  import arpc_pkg::*;
#(
  parameter int unsigned Entries = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ram_req_t   req_i,
  output slot_word_t      rd_slot_o
);

  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;

  slot_word_t             mem [Entries];
  logic [Entries-1:0]     written_q;
  slot_word_t             rdata_q;
  logic                   rwritten_q;

  // memory array: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  // written flags, cleared all at once by reset or flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        written_q <= '0;
      end else if (req_i.wr_en) begin
        written_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rwritten_q <= written_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  // a slot never written since flush reads as empty
  always_comb begin
    rd_slot_o = rdata_q;
    if (!rwritten_q) begin
      rd_slot_o.state = SLOT_EMPTY;
    end
  end

endmodule

`default_nettype wire

>>> design/arp_cache_table_core.sv
// top level of the ip-to-mac address cache: controller, scan and result register
// depends on arpc_pkg, arpc_ifs.sv, arpc_slot_ram and arp_cache_table_core_assert.svh
//
//   port     dir  kind               payload
//   cmd_i    in   arpc_cmd_if.sink   cmd, ip, mac
//   rsp_o    out  arpc_rsp_if.source hit, mac_out, entry_count
//
// lookup, mark pending and insert sweep every slot before the result register loads;
// flush skips the sweep. The read sweep goes over the slot memory one slot per cycle
// through its single read port.
// One command is in work at a time; a result waiting in the output register
// does not stop the next command from being accepted.
// Reset and flush empty the table at once through per-slot written flags.
`default_nettype none

`include "arp_cache_table_core_assert.svh"

module arp_cache_table_core
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  arpc_cmd_if.sink   cmd_i,
  arpc_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(CACHE_ENTRIES - 1);

  fsm_state_e          state_q, state_d;
  cmd_e                cmd_q;
  logic [IpW-1:0]      ip_q;
  logic [MacW-1:0]     mac_q;
  logic                issue_q;
  logic [AW-1:0]       idx_q;
  logic                rvalid_q;
  logic [AW-1:0]       ridx_q;
  logic                have_live_q;
  logic [AW-1:0]       live_idx_q;
  logic                live_res_q;
  logic                have_empty_q;
  logic [AW-1:0]       empty_idx_q;
  logic                have_hit_q;
  logic [MacW-1:0]     hit_mac_q;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q;
  logic                out_hit_q;
  logic [MacW-1:0]     out_mac_q;
  logic [CountW-1:0]   out_count_q;

  logic                accept;
  logic                out_load;
  logic                mac_ok;
  logic                ip_match;
  ram_req_t            req;
  slot_word_t          rd_slot;

  arpc_slot_ram #(
    .Entries(CACHE_ENTRIES)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_slot_o(rd_slot)
  );

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign mac_ok      = (mac_q != '0) && (mac_q != BroadcastMac);
  assign ip_match    = (rd_slot.ip == ip_q);

  // next state, memory requests and counter update
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    out_load = 1'b0;
    req      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_e'(cmd_i.cmd) == CMD_FLUSH) begin
            req.clear = 1'b1;
            count_d   = '0;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        req.rd_en   = issue_q;
        req.rd_addr = SlotIdxW'(idx_q);
        if (rvalid_q && (ridx_q == LastIdx)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        req.wr_data.ip    = ip_q;
        req.wr_data.mac   = mac_q;
        req.wr_data.state = SLOT_RESOLVED;
        unique case (cmd_q)
          CMD_MARK_PENDING: begin
            if (!have_live_q && have_empty_q) begin
              req.wr_en         = 1'b1;
              req.wr_addr       = SlotIdxW'(empty_idx_q);
              req.wr_data.mac   = '0;
              req.wr_data.state = SLOT_PENDING;
            end
          end
          CMD_INSERT: begin
            if (mac_ok) begin
              req.wr_en = 1'b1;
              if (have_live_q) begin
                req.wr_addr = SlotIdxW'(live_idx_q);
                if (!live_res_q && (count_q != CountMax)) begin
                  count_d = count_q + 1'b1;
                end
              end else if (have_empty_q) begin
                req.wr_addr = SlotIdxW'(empty_idx_q);
                if (count_q != CountMax) begin
                  count_d = count_q + 1'b1;
                end
              end else begin
                // full table: slot 0 is overwritten, count stays
                req.wr_addr = '0;
              end
            end
          end
          default: begin
          end
        endcase
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // command capture and sweep bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q      <= 1'b0;
      idx_q        <= '0;
      rvalid_q     <= 1'b0;
      ridx_q       <= '0;
      have_live_q  <= 1'b0;
      have_empty_q <= 1'b0;
      have_hit_q   <= 1'b0;
      cmd_q        <= CMD_LOOKUP;
    end else begin
      rvalid_q <= (state_q == ST_SCAN) && issue_q;
      ridx_q   <= idx_q;
      if (accept) begin
        cmd_q        <= cmd_e'(cmd_i.cmd);
        issue_q      <= (cmd_e'(cmd_i.cmd) != CMD_FLUSH);
        idx_q        <= '0;
        have_live_q  <= 1'b0;
        have_empty_q <= 1'b0;
        have_hit_q   <= 1'b0;
      end else if ((state_q == ST_SCAN) && issue_q) begin
        if (idx_q == LastIdx) begin
          issue_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      // keep the lowest slot of each kind as read data returns
      if (rvalid_q) begin
        if (!have_live_q && (rd_slot.state != SLOT_EMPTY) && ip_match) begin
          have_live_q <= 1'b1;
        end
        if (!have_empty_q && (rd_slot.state == SLOT_EMPTY)) begin
          have_empty_q <= 1'b1;
        end
        if (!have_hit_q && (rd_slot.state == SLOT_RESOLVED) && ip_match) begin
          have_hit_q <= 1'b1;
        end
      end
    end
  end

  // payload of the sweep, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ip_q  <= cmd_i.ip;
      mac_q <= cmd_i.mac;
    end
    if (rvalid_q) begin
      if (!have_live_q && (rd_slot.state != SLOT_EMPTY) && ip_match) begin
        live_idx_q <= ridx_q;
        live_res_q <= (rd_slot.state == SLOT_RESOLVED);
      end
      if (!have_empty_q && (rd_slot.state == SLOT_EMPTY)) begin
        empty_idx_q <= ridx_q;
      end
      if (!have_hit_q && (rd_slot.state == SLOT_RESOLVED) && ip_match) begin
        hit_mac_q <= rd_slot.mac;
      end
    end
  end

  // output register for the response transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= (cmd_q == CMD_LOOKUP) && have_hit_q;
      out_mac_q   <= ((cmd_q == CMD_LOOKUP) && have_hit_q) ? hit_mac_q : '0;
      out_count_q <= count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.mac_out     = out_mac_q;
  assign rsp_o.entry_count = out_count_q;

  // checks
  `ARPC_ASSERT(a_accept_no_read_inflight, clk_i, rst_ni, accept |-> !rvalid_q && !issue_q)
  `ARPC_ASSERT_NEVER(a_no_write_in_sweep, clk_i, rst_ni, req.wr_en && (state_q != ST_UPDATE))
  `ARPC_ASSERT(a_hit_has_mac, clk_i, rst_ni, (rsp_o.valid && rsp_o.hit) |-> (rsp_o.mac_out != '0))
  `ARPC_ASSERT(a_update_then_finish, clk_i, rst_ni, (state_q == ST_UPDATE) |=> (state_q == ST_FINISH))

endmodule

`default_nettype wire

>>> sim/arpc_reply_checker.sv
// reply checker for the ip-to-mac address cache: predicts each reply and compares it
// depends on arpc_pkg and the channel interfaces in arpc_ifs.sv
module arpc_reply_checker
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  arpc_cmd_if  cmd_mon_i,
  arpc_rsp_if  rsp_mon_i,
  output int   err_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit;
    logic [MacW-1:0]   mac;
    logic [CountW-1:0] count;
  } arp_reply_t;

  // shadow copy of the cache contents
  slot_state_e       cache_state [CACHE_ENTRIES];
  logic [IpW-1:0]    cache_ip    [CACHE_ENTRIES];
  logic [MacW-1:0]   cache_mac   [CACHE_ENTRIES];
  logic [CountW-1:0] resolved_n;

  // replies still owed by the block, oldest first
  arp_reply_t        reply_q[$];

  function automatic void clear_cache();
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      cache_state[i] = SLOT_EMPTY;
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
    end
    resolved_n = '0;
  endfunction

  // lowest non-empty slot holding the address, or -1
  function automatic int live_slot(logic [IpW-1:0] ip);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (cache_state[i] != SLOT_EMPTY && cache_ip[i] == ip) return i;
    return -1;
  endfunction

  // lowest empty slot, or -1
  function automatic int free_slot();
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (cache_state[i] == SLOT_EMPTY) return i;
    return -1;
  endfunction

  function automatic void bump_count();
    if (resolved_n != CountMax) resolved_n = resolved_n + 1'b1;
  endfunction

  // apply one command to the shadow cache and return the reply it gives
  function automatic arp_reply_t apply_cmd(cmd_e op, logic [IpW-1:0] ip,
                                           logic [MacW-1:0] mac);
    arp_reply_t r;
    int         slot;
    r = '0;
    case (op)
      CMD_LOOKUP: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!r.hit && cache_state[i] == SLOT_RESOLVED && cache_ip[i] == ip) begin
            r.hit = 1'b1;
            r.mac = cache_mac[i];
          end
        end
      end
      CMD_MARK_PENDING: begin
        if (live_slot(ip) < 0) begin
          slot = free_slot();
          if (slot >= 0) begin
            cache_ip[slot]    = ip;
            cache_mac[slot]   = '0;
            cache_state[slot] = SLOT_PENDING;
          end
        end
      end
      CMD_INSERT: begin
        // zero and broadcast addresses are dropped
        if (mac != '0 && mac != BroadcastMac) begin
          slot = live_slot(ip);
          if (slot >= 0) begin
            cache_mac[slot] = mac;
            if (cache_state[slot] != SLOT_RESOLVED) begin
              cache_state[slot] = SLOT_RESOLVED;
              bump_count();
            end
          end else begin
            // full table overwrites slot 0 without counting
            slot = free_slot();
            if (slot >= 0) bump_count();
            else slot = 0;
            cache_ip[slot]    = ip;
            cache_mac[slot]   = mac;
            cache_state[slot] = SLOT_RESOLVED;
          end
        end
      end
      default: clear_cache();
    endcase
    r.count = resolved_n;
    return r;
  endfunction

  // compare replies first, then queue the prediction for a new command
  always @(posedge clk_i or negedge rst_ni) begin
    arp_reply_t want;
    arp_reply_t got;
    if (!rst_ni) begin
      clear_cache();
      reply_q.delete();
      err_count_o = 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        got = {rsp_mon_i.hit, rsp_mon_i.mac_out, rsp_mon_i.entry_count};
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none expected, got hit %0d mac %h count %0d",
                   $time, got.hit, got.mac, got.count);
          err_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            if (got.hit !== want.hit)
              $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
            if (got.mac !== want.mac)
              $display("%0t: mac_out expected %h got %h", $time, want.mac, got.mac);
            if (got.count !== want.count)
              $display("%0t: entry_count expected %0d got %0d",
                       $time, want.count, got.count);
            err_count_o++;
          end
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready)
        reply_q.push_back(apply_cmd(cmd_e'(cmd_mon_i.cmd), cmd_mon_i.ip, cmd_mon_i.mac));
    end
    outstanding_o <= reply_q.size();
  end

endmodule

>>> sim/tb_arp_cache_table_core.sv
// top of the address cache testbench: clock, reset, command stimulus and verdict
// depends on arpc_pkg, arpc_ifs.sv, the cache rtl and sim/arpc_reply_checker.sv
module tb_arp_cache_table_core
  import arpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries    = 16;
  localparam int          ItemsTotal = 1400;
  localparam int          QuietLimit = 4000;

  logic clk;
  logic rst_n;
  int   err_count;
  int   outstanding;
  int   quiet_cycles;
  int   sent_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  arpc_cmd_if cmd_if ();
  arpc_rsp_if rsp_if ();

  arp_cache_table_core #(.CACHE_ENTRIES(Entries)) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  arpc_reply_checker #(.CACHE_ENTRIES(Entries)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cmd_mon_i     (cmd_if),
    .rsp_mon_i     (rsp_if),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reply side back-pressure
  always @(posedge clk) begin
    rsp_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MacW-1:0];
  endfunction

  // small address pool so that commands collide, plus fully random addresses
  function automatic logic [IpW-1:0] pick_ip();
    int k;
    if ($urandom_range(99) >= 70) return $urandom;
    k = $urandom_range(23);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return 32'hC0A8_0100 + k;
  endfunction

  function automatic logic [MacW-1:0] pick_mac();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return BroadcastMac;
    return rand_mac();
  endfunction

  // one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(cmd_e op, logic [IpW-1:0] ip, logic [MacW-1:0] mac);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= op;
    cmd_if.ip    <= ip;
    cmd_if.mac   <= mac;
    do begin
      @(negedge clk);
      taken = cmd_if.ready;
      @(posedge clk);
    end while (!taken);
    sent_n++;
  endtask

  // hold off until every reply is back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    int          r;
    cmd_e        op;
    logic [31:0] ip;
    rst_n          = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.cmd     = CMD_LOOKUP;
    cmd_if.ip      = '0;
    cmd_if.mac     = '0;
    rsp_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_n         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, rejected addresses, pending to resolved, flush
    send_cmd(CMD_LOOKUP, '0, rand_mac());
    send_cmd(CMD_INSERT, 32'hC0A8_0001, '0);
    send_cmd(CMD_INSERT, 32'hC0A8_0001, BroadcastMac);
    send_cmd(CMD_LOOKUP, 32'hC0A8_0001, '0);
    send_cmd(CMD_INSERT, '1, 48'h0000_0000_0001);
    send_cmd(CMD_LOOKUP, '1, '0);
    send_cmd(CMD_MARK_PENDING, '0, '1);
    send_cmd(CMD_LOOKUP, '0, '0);
    send_cmd(CMD_MARK_PENDING, '0, '0);
    send_cmd(CMD_MARK_PENDING, '1, '0);
    send_cmd(CMD_INSERT, '0, 48'hFFFF_FFFF_FFFE);
    send_cmd(CMD_LOOKUP, '0, '0);
    send_cmd(CMD_INSERT, '0, 48'h8000_0000_0000);
    send_cmd(CMD_LOOKUP, '0, rand_mac());
    send_cmd(CMD_FLUSH, '1, '1);
    send_cmd(CMD_LOOKUP, '0, '0);
    drain();

    // random traffic over four idling phases
    sent_n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      while (sent_n < (ph + 1) * ItemsTotal / 4) begin
        if ($urandom_range(99) < 35) begin
          // resolve sequence for one address
          ip = pick_ip();
          send_cmd(CMD_MARK_PENDING, ip, rand_mac());
          send_cmd(CMD_INSERT, ip, pick_mac());
          send_cmd(CMD_LOOKUP, ip, rand_mac());
        end else begin
          r  = $urandom_range(99);
          op = (r < 3) ? CMD_FLUSH : (r < 38) ? CMD_LOOKUP :
               (r < 58) ? CMD_MARK_PENDING : CMD_INSERT;
          send_cmd(op, pick_ip(), pick_mac());
        end
      end
      drain();
    end

    repeat (2 * (Entries + 3)) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
